FILE: rtl/core/tlt_pkg.sv
// Shared types and constants of the timestamp list trigger.
`timescale 1ns / 1ps

package tlt_pkg;

	// Default sizes for the top-level parameters
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int TIME_WIDTH_DEF  = 48;

	// Fixed field widths of the channels
	localparam int ENTRY_IDX_W  = 10;
	localparam int ENTRY_TIME_W = 48;
	localparam int READ_POS_W   = 11;
	localparam int LIST_LEN_W   = 11;
	localparam int OFFSET_W     = 48;
	localparam int STEP_W       = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 48;

	// Reset value of the time step: one unit with 16 fraction bits
	localparam logic [STEP_W-1:0] TIME_STEP_RST = 32'h0001_0000;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Item operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd2;

	// Classified command handed from front to back
	typedef struct packed {
		logic                           is_write;
		logic                           reset_level;
		logic                           idx_ok;
		logic [ENTRY_IDX_W-1:0]         entry_index;
		logic signed [ENTRY_TIME_W-1:0] entry_time;
	} cmd_t;

endpackage

FILE: rtl/core/tlt_item_if.sv
// Input channel: tick and table-write words.
`timescale 1ns / 1ps

interface tlt_item_if;
	import tlt_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           op;
	logic                           reset_level;
	logic [ENTRY_IDX_W-1:0]         entry_index;
	logic signed [ENTRY_TIME_W-1:0] entry_time;

	modport source (output valid, op, reset_level, entry_index, entry_time, input ready);
	modport sink (input valid, op, reset_level, entry_index, entry_time, output ready);
endinterface

FILE: rtl/core/tlt_result_if.sv
// Output channel: one result word per tick.
`timescale 1ns / 1ps

interface tlt_result_if;
	import tlt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  fired;
	logic [READ_POS_W-1:0] read_position;

	modport source (output valid, fired, read_position, input ready);
	modport sink (input valid, fired, read_position, output ready);
endinterface

FILE: rtl/core/tlt_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps

interface tlt_cfg_if;
	import tlt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/timestamp_list_trigger.sv
// Top level of the timestamp list trigger.
`timescale 1ns / 1ps

// Usage:
//   item   : input words. op selects a tick or a table write; a write loads
//            entry_time into entry entry_index, a tick steps the trigger.
//   result : one word per tick with fired and the read position after it.
//   cfg    : register writes (list length, start offset, time step), taken
//            every cycle; write them only while the block is idle.
// Queue and walk:
//   A two-word command queue sits behind the input, so words are taken
//   while the back end is busy or the result word waits.
//   A table write is done at the queue head while the back end is idle.
//   A tick steps through the idle, read and compare states; the table
//   walk reads one entry per cycle from the single RAM read port.
//   The result word is registered from the walk's final position.
// Reset: arst_n clears position, time, reset level, queue and result; the
//   time step returns to one unit. Table contents stay undefined.
// Stall: a held result word stops the back end at the end of the next tick;
//   the queue then fills and input ready drops.
module timestamp_list_trigger #(
	parameter int TABLE_DEPTH = tlt_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_WIDTH  = tlt_pkg::TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tlt_item_if.sink     item,
	tlt_result_if.source result,
	tlt_cfg_if.sink      cfg
);
	import tlt_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	tlt_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	tlt_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

FILE: rtl/core/tlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry each cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/tlt_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps

module tlt_front #(
	parameter int TABLE_DEPTH = tlt_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tlt_item_if.sink      item,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output tlt_pkg::cmd_t cmd
);
	import tlt_pkg::*;

	localparam int POS_W   = $clog2(TABLE_DEPTH + 1);
	localparam int IDXC_W  = (POS_W > ENTRY_IDX_W) ? POS_W : ENTRY_IDX_W;
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              push;
	logic              pop;

	// Classify the incoming word
	always_comb begin
		cls.is_write    = (item.op == OP_WRITE);
		cls.reset_level = item.reset_level;
		cls.idx_ok      = IDXC_W'(item.entry_index) < IDXC_W'(TABLE_DEPTH);
		cls.entry_index = item.entry_index;
		cls.entry_time  = item.entry_time;
	end

	assign item.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (count_q != '0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = queue_q[rd_ptr_q];

	// Store the classified word
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/tlt_back.sv
// Back end: table writes, restart, table walk, time step and result register.
`timescale 1ns / 1ps

module tlt_back #(
	parameter int TABLE_DEPTH = tlt_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_WIDTH  = tlt_pkg::TIME_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tlt_pkg::cmd_t cmd,
	tlt_cfg_if.sink       cfg,
	tlt_result_if.source  result
);
	import tlt_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int POS_W  = $clog2(TABLE_DEPTH + 1);
	localparam int LEN_W  = (POS_W > LIST_LEN_W) ? POS_W : LIST_LEN_W;
	localparam int OUT_W  = (POS_W > READ_POS_W) ? POS_W : READ_POS_W;
	localparam int CMP_W  = (TIME_WIDTH > ENTRY_TIME_W) ? TIME_WIDTH : ENTRY_TIME_W;
	localparam int NEG_W  = ((TIME_WIDTH > OFFSET_W) ? TIME_WIDTH : OFFSET_W) + 1;
	localparam int SUM_W  = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_CMP  = 3'b100
	} state_t;

	state_t                       state_q;
	logic [LIST_LEN_W-1:0]        list_length_q;
	logic signed [OFFSET_W-1:0]   start_offset_q;
	logic [STEP_W-1:0]            time_step_q;
	logic [POS_W-1:0]             next_entry_q;
	logic signed [TIME_WIDTH-1:0] current_time_q;
	logic                         last_level_q;
	logic                         fired_q;
	logic                         out_valid_q;
	logic                         out_fired_q;
	logic [READ_POS_W-1:0]        out_pos_q;

	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [ENTRY_TIME_W-1:0]      ram_rdata;
	logic [LEN_W-1:0]             len_ext;
	logic [LEN_W-1:0]             len_eff;
	logic signed [CMP_W-1:0]      entry_cmp;
	logic signed [CMP_W-1:0]      time_cmp;
	logic                         adv;
	logic [POS_W-1:0]             next_inc;
	logic [POS_W-1:0]             next_sel;
	logic                         out_free;
	logic                         finish;
	logic [OUT_W-1:0]             pos_ext;
	logic signed [NEG_W-1:0]      neg_off;
	logic signed [NEG_W-1:0]      neg_max;
	logic signed [NEG_W-1:0]      neg_min;
	logic signed [TIME_WIDTH-1:0] restart_time;
	logic signed [SUM_W-1:0]      time_ext;
	logic signed [SUM_W-1:0]      step_ext;
	logic signed [SUM_W-1:0]      sum;
	logic signed [SUM_W-1:0]      sum_max;
	logic signed [TIME_WIDTH-1:0] stepped_time;

	assign cfg.ready = 1'b1;

	// Latch configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q  <= '0;
			start_offset_q <= '0;
			time_step_q    <= TIME_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LIST_LENGTH:  list_length_q  <= cfg.data[LIST_LEN_W-1:0];
				REG_START_OFFSET: start_offset_q <= cfg.data[OFFSET_W-1:0];
				REG_TIME_STEP:    time_step_q    <= cfg.data[STEP_W-1:0];
				default:          ;
			endcase
		end
	end

	// Saturate the list length to the table depth
	assign len_ext = LEN_W'(list_length_q);
	assign len_eff = (len_ext > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_ext;

	// Compare the pending entry against the current time
	assign entry_cmp = CMP_W'($signed(ram_rdata));
	assign time_cmp  = CMP_W'(current_time_q);
	assign adv       = (state_q == ST_CMP) && (LEN_W'(next_entry_q) < len_eff)
	                   && (entry_cmp <= time_cmp);
	assign next_inc  = next_entry_q + 1'b1;
	assign next_sel  = adv ? next_inc : next_entry_q;
	assign ram_raddr = next_sel[ADDR_W-1:0];

	// Table write straight from the queue head
	assign cmd_ready = (state_q == ST_IDLE);
	assign ram_we    = cmd_valid && cmd_ready && cmd.is_write && cmd.idx_ok;
	assign ram_waddr = ADDR_W'(cmd.entry_index);

	tlt_ram #(
		.WIDTH (ENTRY_TIME_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.entry_time),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Restart time: negated offset, clamped to the time range
	assign neg_max = {{(NEG_W - TIME_WIDTH + 1){1'b0}}, {(TIME_WIDTH - 1){1'b1}}};
	assign neg_min = ~neg_max;
	assign neg_off = -NEG_W'(start_offset_q);
	always_comb begin
		if (neg_off > neg_max) begin
			restart_time = neg_max[TIME_WIDTH-1:0];
		end else if (neg_off < neg_min) begin
			restart_time = neg_min[TIME_WIDTH-1:0];
		end else begin
			restart_time = neg_off[TIME_WIDTH-1:0];
		end
	end

	// Step the time, saturating at the top of the range
	assign sum_max  = {{(SUM_W - TIME_WIDTH + 1){1'b0}}, {(TIME_WIDTH - 1){1'b1}}};
	assign time_ext = SUM_W'(current_time_q);
	assign step_ext = SUM_W'(time_step_q);
	assign sum      = time_ext + step_ext;
	assign stepped_time = (sum > sum_max) ? sum_max[TIME_WIDTH-1:0] : sum[TIME_WIDTH-1:0];

	assign out_free = !out_valid_q || result.ready;
	assign finish   = (state_q == ST_CMP) && !adv && out_free;
	assign pos_ext  = OUT_W'(next_entry_q);

	// Sequence a tick: restart check, walk, time step, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			next_entry_q   <= '0;
			current_time_q <= '0;
			last_level_q   <= 1'b0;
			fired_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && !cmd.is_write) begin
						if (cmd.reset_level && !last_level_q) begin
							next_entry_q   <= '0;
							current_time_q <= restart_time;
						end
						last_level_q <= cmd.reset_level;
						fired_q      <= 1'b0;
						state_q      <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (adv) begin
						next_entry_q <= next_inc;
						fired_q      <= 1'b1;
					end else if (finish) begin
						current_time_q <= stepped_time;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_fired_q <= fired_q;
			out_pos_q   <= pos_ext[READ_POS_W-1:0];
		end
	end

	assign result.valid         = out_valid_q;
	assign result.fired         = out_fired_q;
	assign result.read_position = out_pos_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_entry_q <= POS_W'(TABLE_DEPTH))
		else $error("read position beyond table depth");

	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("table write during a walk");

	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CMP))
		else $error("result word raised outside the walk");

	a_read_then_compare: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_CMP && $stable(next_entry_q))
		else $error("read cycle not followed by compare");

endmodule
